// ===== sv/frsl_pkg.sv =====
// ----------------------------------------------------------------------------
// frsl_pkg
// Shared types and constants for the fractional slew-rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package frsl_pkg;

  // Field widths
  localparam int unsigned ValW  = 16;
  localparam int unsigned IncW  = 17;
  localparam int unsigned CfgW  = 15;
  localparam int unsigned IdxW  = 2;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_RUN_LENGTH     = 2'd0,
    CFG_BASE_INCREMENT = 2'd1,
    CFG_STEP_REMAINDER = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] RunLengthRst     = 15'd1;
  localparam logic [CfgW-1:0] BaseIncrementRst = 15'd0;
  localparam logic [CfgW-1:0] StepRemainderRst = 15'd0;

  // Rate settings seen by the step logic
  typedef struct packed {
    logic [CfgW-1:0] run_length;
    logic [CfgW-1:0] base_increment;
    logic [CfgW-1:0] step_remainder;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/frsl_cfg.sv =====
// ----------------------------------------------------------------------------
// frsl_cfg
// Configuration registers of the slew-rate limiter, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module frsl_cfg import frsl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  // Update the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_length     <= RunLengthRst;
      cfg_q.base_increment <= BaseIncrementRst;
      cfg_q.step_remainder <= StepRemainderRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RUN_LENGTH:     cfg_q.run_length     <= cfg_data_i;
        CFG_BASE_INCREMENT: cfg_q.base_increment <= cfg_data_i;
        CFG_STEP_REMAINDER: cfg_q.step_remainder <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/frsl_step.sv =====
// ----------------------------------------------------------------------------
// frsl_step
// Combinational step computation: error accumulator update, rollover,
// clamp to the remaining distance and sign of the increment.
// ----------------------------------------------------------------------------
`default_nettype none

module frsl_step import frsl_pkg::*; (
  input  wire logic signed [ValW-1:0] cur_i,
  input  wire logic signed [ValW-1:0] tgt_i,
  input  wire logic        [ValW-1:0] err_i,
  input  cfg_t                        cfg_i,
  output logic             [IncW-1:0] incr_o,
  output logic             [ValW-1:0] err_o
);

  logic signed [IncW-1:0] diff;
  logic                   up;
  logic        [IncW-1:0] mag;
  logic signed [17:0]     err_x;
  logic signed [17:0]     rem_x;
  logic signed [17:0]     run_x;
  logic signed [17:0]     acc;
  logic                   roll;
  logic signed [17:0]     acc_adj;
  logic        [ValW-1:0] step;
  logic        [IncW-1:0] step_c;
  logic                   clamp;

  // Exact difference and direction
  assign diff = IncW'(tgt_i) - IncW'(cur_i);
  assign up   = !diff[IncW-1] && (diff != '0);
  assign mag  = up ? diff : (IncW'(0) - diff);

  // Accumulate the remainder and test for rollover
  assign err_x = 18'($signed(err_i));
  assign rem_x = $signed({3'b000, cfg_i.step_remainder});
  assign run_x = $signed({3'b000, cfg_i.run_length});
  assign acc   = up ? (err_x + rem_x) : (err_x - rem_x);
  assign roll  = up ? (acc >= run_x) : (acc <= (18'sd0 - run_x));
  assign acc_adj = roll ? (up ? (acc - run_x) : (acc + run_x)) : acc;

  // Base step plus the extra unit on rollover
  assign step = {1'b0, cfg_i.base_increment} + ValW'(roll);

  // Clamp to the remaining distance and clear the error near the target
  assign clamp  = mag <= {1'b0, step};
  assign step_c = clamp ? mag : {1'b0, step};
  assign err_o  = clamp ? '0 : acc_adj[ValW-1:0];
  assign incr_o = up ? step_c : (IncW'(0) - step_c);

endmodule

`default_nettype wire

// ===== sv/fractional_slew_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// fractional_slew_rate_limiter
// Returns a signed step from the current value toward the target value at
// an average rate of rise/run per transaction, with Bresenham-style error
// accumulation and a clamp to the remaining distance.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  in       | in_valid_i/in_stall_o | current_value_i, target_value_i
//  out      | out_valid_o/out_stall_i | increment_o
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// Each transaction is captured in the input register and leaves through
// the result register, one transaction per cycle unless the output stalls.
// The error accumulator is updated as a transaction moves into the result
// register, so the next one sees it without a bubble.
// Reset clears the valid flags and error accumulator, and sets the reset rates.
// A stall on the output holds the result register, then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_slew_rate_limiter import frsl_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic        [IdxW-1:0] cfg_idx_i,
  input  wire logic        [CfgW-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [ValW-1:0] current_value_i,
  input  wire logic signed [ValW-1:0] target_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed      [IncW-1:0] increment_o
);

  cfg_t                   cfg;
  logic                   s1_valid_q;
  logic signed [ValW-1:0] cur_q;
  logic signed [ValW-1:0] tgt_q;
  logic                   out_valid_q;
  logic        [IncW-1:0] incr_q;
  logic        [IncW-1:0] incr_d;
  logic        [ValW-1:0] err_q;
  logic        [ValW-1:0] err_d;
  logic                   out_adv;
  logic                   s1_fire;
  logic                   in_acc;

  frsl_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  frsl_step u_step (
    .cur_i  (cur_q),
    .tgt_i  (tgt_q),
    .err_i  (err_q),
    .cfg_i  (cfg),
    .incr_o (incr_d),
    .err_o  (err_d)
  );

  // Pipeline advance control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Valid flags and error accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      err_q       <= '0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !out_adv);
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        err_q <= err_d;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= current_value_i;
      tgt_q <= target_value_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      incr_q <= incr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign increment_o = $signed(incr_q);

endmodule

`default_nettype wire

// ===== tb/sv/fractional_slew_rate_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// fractional_slew_rate_limiter_tb
// Self-checking bench for the slew-rate limiter. A queue of pending
// transactions feeds a clocked driver. A clocked monitor compares every
// result with the increment worked out by a local step predictor. The rate
// settings change between phases, including the run length of zero and
// remainders at or above the run length. Random gaps and stalls fall on
// both channels, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------

module fractional_slew_rate_limiter_tb;
  import frsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Unmapped register index, writes to it must be ignored
  localparam logic [IdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int BlockAt       = 400;
  localparam int BlockCycles   = 200;
  localparam int RandomPhases  = 14;
  localparam int PhaseItems    = 68;

  typedef struct packed {
    logic signed [ValW-1:0] cur;
    logic signed [ValW-1:0] tgt;
  } sample_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic        [IdxW-1:0] cfg_idx_i       = CFG_RUN_LENGTH;
  logic        [CfgW-1:0] cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  logic signed [ValW-1:0] current_value_i = '0;
  logic signed [ValW-1:0] target_value_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  logic signed [IncW-1:0] increment_o;

  // Mirror of the rate settings and the error accumulator
  logic        [CfgW-1:0] run_len  = RunLengthRst;
  logic        [CfgW-1:0] base_inc = BaseIncrementRst;
  logic        [CfgW-1:0] step_rem = StepRemainderRst;
  logic signed [ValW-1:0] err_acc  = '0;

  sample_t                pending_samples[$];
  logic signed [IncW-1:0] increments_due[$];
  sample_t                in_next;
  logic signed [IncW-1:0] inc_exp;

  int in_sent     = 0;
  int out_seen    = 0;
  int in_wait     = 0;
  int out_hold    = 0;
  int block_left  = 0;
  bit block_done  = 1'b0;
  bit in_quiet    = 1'b0;
  bit out_quiet   = 1'b0;
  int errors      = 0;
  int rate_sets   = 0;

  fractional_slew_rate_limiter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .current_value_i (current_value_i),
    .target_value_i  (target_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .increment_o     (increment_o)
  );

  // Advance the accumulator by one transaction and return the signed step
  function automatic logic signed [IncW-1:0] predict_increment(
    logic signed [ValW-1:0] cur,
    logic signed [ValW-1:0] tgt
  );
    int diff;
    int acc;
    int run;
    int stp;
    int mag;
    bit up;
    diff = int'(tgt) - int'(cur);
    acc  = int'(err_acc);
    run  = int'(run_len);
    stp  = int'(base_inc);
    up   = diff > 0;
    if (up) begin
      mag = diff;
      acc += int'(step_rem);
      if (acc >= run) begin
        stp++;
        acc -= run;
      end
    end else begin
      mag = -diff;
      acc -= int'(step_rem);
      if (acc <= -run) begin
        stp++;
        acc += run;
      end
    end
    // Clamp to the remaining distance and clear the error near the target
    if (mag <= stp) begin
      stp = mag;
      acc = 0;
    end
    if (!up) stp = -stp;
    err_acc = acc[ValW-1:0];
    return stp[IncW-1:0];
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic push_sample(int c, int t);
    sample_t s;
    s.cur = c[ValW-1:0];
    s.tgt = t[ValW-1:0];
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_RUN_LENGTH:     run_len  = val;
      CFG_BASE_INCREMENT: base_inc = val;
      CFG_STEP_REMAINDER: step_rem = val;
      default: ;
    endcase
  endtask

  // Program all three rate registers, now and then poke the spare index too
  task automatic apply_rates(int run, int base, int rem);
    write_reg(CFG_RUN_LENGTH, run[CfgW-1:0]);
    write_reg(CFG_BASE_INCREMENT, base[CfgW-1:0]);
    write_reg(CFG_STEP_REMAINDER, rem[CfgW-1:0]);
    if ($urandom_range(0, 2) == 0) write_reg(CfgIdxSpare, CfgW'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_sets++;
    @(negedge clk_i);
  endtask

  // Wait until every queued transaction has come back, then let the pipe drain
  task automatic settle();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || increments_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Walk the current value toward a held target, with a little jitter
  task automatic queue_glide(int len);
    int c;
    int t;
    int span;
    int k;
    t    = int'($urandom_range(0, 65535)) - 32768;
    span = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 200));
    c    = clip16($urandom_range(0, 1) ? t + span : t - span);
    for (k = 0; k < len; k++) begin
      push_sample(c, t);
      c = clip16(c + (t - c) / (len - k) + int'($urandom_range(0, 2)) - 1);
    end
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Driver: present queued transactions, hold them while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        increments_due.push_back(predict_increment(current_value_i, target_value_i));
        in_sent <= in_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_wait == 0 && pending_samples.size() != 0) begin
          in_next = pending_samples.pop_front();
          current_value_i <= in_next.cur;
          target_value_i  <= in_next.tgt;
          in_valid_i      <= 1'b1;
          in_wait = in_quiet ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
          if (in_wait != 0) in_wait--;
        end
      end
    end
  end

  // Long output hold-off once the random traffic is under way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!block_done && in_sent == BlockAt) begin
        block_left <= BlockCycles;
        block_done <= 1'b1;
      end else if (block_left != 0) begin
        block_left <= block_left - 1;
      end
    end
  end

  // Monitor: check each result against the oldest expected increment
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (increments_due.size() == 0) begin
          $error("increment: no result expected, got %0d", increment_o);
          errors++;
        end else begin
          inc_exp = increments_due.pop_front();
          if (increment_o !== inc_exp) begin
            $error("increment: expected %0d, got %0d", inc_exp, increment_o);
            errors++;
          end
        end
        out_seen <= out_seen + 1;
        out_hold = out_quiet ? 0 : $urandom_range(0, 3);
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0) || (block_left != 0);
    end
  end

  // Stimulus
  initial begin
    int p;
    int n;
    int len;
    int run;
    int base;
    int rem;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset rates: base of zero, every step is zero
    push_sample(0, 0);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(5, 5);
    settle();

    // Run length zero with the widest base and remainder: extra unit every
    // transaction and the accumulator wraps
    apply_rates(0, 32767, 32767);
    push_sample(-32768, 32767);
    push_sample(-32768, 32767);
    push_sample(32767, -32768);
    push_sample(32767, -32768);
    push_sample(0, 0);
    push_sample(100, 0);
    push_sample(0, 100);
    push_sample(-1, 0);
    push_sample(0, -1);
    settle();

    // Widest run with the remainder equal to it
    apply_rates(32767, 0, 32767);
    push_sample(0, 1000);
    push_sample(0, 1000);
    push_sample(1000, 0);
    push_sample(1000, 0);
    settle();

    // Small fractional rate: rollovers, a reversal and the clamp to target
    apply_rates(3, 2, 1);
    push_sample(0, 50);
    push_sample(2, 50);
    push_sample(4, 50);
    push_sample(50, 0);
    push_sample(48, 0);
    push_sample(0, 2);
    push_sample(0, 3);
    settle();

    // Random rate settings, mostly glides toward a target with some noise
    for (p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 4))
        0: run = 0;
        1: run = 1;
        2: run = 32767;
        3: run = $urandom_range(2, 16);
        default: run = $urandom_range(1, 32767);
      endcase
      case ($urandom_range(0, 5))
        0: base = 0;
        1: base = 32767;
        2, 3: base = $urandom_range(0, 8);
        default: base = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 4))
        0: rem = 0;
        1: rem = 32767;
        4: rem = $urandom_range(0, 32767);
        default: rem = (run > 0) ? int'($urandom_range(0, run - 1)) : 0;
      endcase
      apply_rates(run, base, rem);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(0, 6) == 0) begin
          push_sample($urandom, $urandom);
          n++;
        end else begin
          len = $urandom_range(4, 24);
          queue_glide(len);
          n += len;
        end
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d transactions checked under %0d rate settings,", out_seen, rate_sets + 1);
    $display("covering run length zero, wrapped error and a long output stall");
    if (errors == 0) begin
      $display("fractional_slew_rate_limiter_tb: clean");
    end else begin
      $display("fractional_slew_rate_limiter_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("fractional_slew_rate_limiter_tb: errors");
    $finish;
  end

endmodule
